// ===== src/utf8_to_utf16_decoder_top_assert.svh =====
// Assertion macros for the UTF-8 to UTF-16 decoder checker.
// Used by utd_checker.sv only; no other dependencies.
`ifndef UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utd assertion failed");

// Next-cycle implication, disabled during reset.
`define UTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utd assertion failed");

`endif

// ===== src/utd_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package utd_pkg;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_LEAD  = 3'd1,
        ERR_RANGE = 3'd2,
        ERR_CONT  = 3'd3,
        ERR_TRUNC = 3'd4
    } t_err;

    // One queue entry: one result, or a surrogate pair (two results).
    typedef struct packed {
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
        logic        pair;
        logic        present;
        t_err        err;
        logic        last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0]  LEAD_E0   = 8'hE0;
    localparam logic [7:0]  LEAD_ED   = 8'hED;
    localparam logic [7:0]  LEAD_F0   = 8'hF0;
    localparam logic [7:0]  LEAD_F4   = 8'hF4;
    localparam logic [7:0]  E0_MIN    = 8'hA0;
    localparam logic [7:0]  CONT_MAX  = 8'hBF;
    localparam logic [7:0]  ED_MAX    = 8'h9F;
    localparam logic [7:0]  F0_MIN    = 8'h90;
    localparam logic [7:0]  F4_MAX    = 8'h8F;
    localparam logic [9:0]  SURR_TAG  = 10'h01B;   // 0xD800 >> 11
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [5:0]  HI_SURR   = 6'b110110;
    localparam logic [5:0]  LO_SURR   = 6'b110111;

endpackage

`default_nettype wire

// ===== src/utd_front.sv =====
// Front end: accepts UTF-8 bytes, validates them and assembles code points.
// Pushes finished results into the queue. Depends on utd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_string_end,
    input  wire logic            i_full,
    output utd_pkg::t_entry      o_entry,
    output logic                 o_push
);
    import utd_pkg::*;

    logic [1:0]  r_pend,    n_pend;
    logic [7:0]  r_lead,    n_lead;
    logic        r_seen,    n_seen;
    logic [20:0] r_acc,     n_acc;
    logic        r_discard, n_discard;

    logic        accept;
    logic        bad2;
    logic [1:0]  npend;
    logic [20:0] acc2;
    logic [20:0] supp;
    t_entry      entry;
    logic        push;

    assign accept = i_valid && !i_full;

    always_comb begin
        n_pend    = r_pend;
        n_lead    = r_lead;
        n_seen    = r_seen;
        n_acc     = r_acc;
        n_discard = r_discard;
        push      = 1'b0;
        entry     = '{unit_hi: 16'd0, unit_lo: 16'd0, pair: 1'b0, present: 1'b0,
                      err: ERR_OK, last: 1'b1};
        bad2      = 1'b0;
        npend     = r_pend - 2'd1;
        acc2      = r_acc;
        supp      = '0;

        if (r_discard) begin
            if (i_string_end) begin
                n_discard = 1'b0;
                n_pend    = '0;
                n_lead    = '0;
                n_seen    = 1'b0;
                n_acc     = '0;
            end
        end else if (r_pend == 2'd0) begin
            if (i_data_byte == 8'd0) begin
                // zero byte ends the string early
                push      = 1'b1;
                n_discard = !i_string_end;
            end else if (!i_data_byte[7]) begin
                push          = 1'b1;
                entry.unit_hi = {8'd0, i_data_byte};
                entry.present = 1'b1;
                entry.last    = i_string_end;
            end else begin
                n_lead = i_data_byte;
                n_seen = 1'b0;
                case (i_data_byte) inside
                    [8'hC2:8'hDF]: begin
                        n_acc  = {10'd0, i_data_byte[4:0], 6'd0};
                        n_pend = 2'd1;
                    end
                    [8'hE0:8'hEF]: begin
                        n_acc  = {5'd0, i_data_byte[3:0], 12'd0};
                        n_pend = 2'd2;
                    end
                    [8'hF0:8'hF4]: begin
                        n_acc  = {i_data_byte[2:0], 18'd0};
                        n_pend = 2'd3;
                    end
                    default: begin
                        push      = 1'b1;
                        entry.err = ERR_LEAD;
                    end
                endcase
                if (push || i_string_end) begin
                    if (!push) begin
                        push      = 1'b1;
                        entry.err = ERR_TRUNC;
                    end
                    n_pend    = '0;
                    n_lead    = '0;
                    n_acc     = '0;
                    n_discard = !i_string_end;
                end
            end
        end else begin
            if (!r_seen) begin
                bad2 = ((r_lead == LEAD_E0) && (i_data_byte < E0_MIN || i_data_byte > CONT_MAX))
                    || ((r_lead == LEAD_ED) && (i_data_byte > ED_MAX))
                    || ((r_lead == LEAD_F0) && (i_data_byte < F0_MIN || i_data_byte > CONT_MAX))
                    || ((r_lead == LEAD_F4) && (i_data_byte > F4_MAX));
            end
            case (npend)
                2'd2:    acc2 = r_acc | {3'd0, i_data_byte[5:0], 12'd0};
                2'd1:    acc2 = r_acc | {9'd0, i_data_byte[5:0], 6'd0};
                default: acc2 = r_acc | {15'd0, i_data_byte[5:0]};
            endcase
            supp = acc2 - SUPP_BASE;

            if (bad2) begin
                push      = 1'b1;
                entry.err = ERR_RANGE;
            end else if (i_data_byte[7:6] != 2'b10) begin
                push      = 1'b1;
                entry.err = ERR_CONT;
            end else if (npend != 2'd0) begin
                if (i_string_end) begin
                    push      = 1'b1;
                    entry.err = ERR_TRUNC;
                end else begin
                    n_pend = npend;
                    n_acc  = acc2;
                    n_seen = 1'b1;
                end
            end else if (acc2[20:11] == SURR_TAG) begin
                push      = 1'b1;
                entry.err = ERR_RANGE;
            end else if (acc2[20:16] != 5'd0) begin
                push          = 1'b1;
                entry.pair    = 1'b1;
                entry.present = 1'b1;
                entry.unit_hi = {HI_SURR, supp[19:10]};
                entry.unit_lo = {LO_SURR, supp[9:0]};
                entry.last    = i_string_end;
            end else begin
                push          = 1'b1;
                entry.present = 1'b1;
                entry.unit_hi = acc2[15:0];
                entry.last    = i_string_end;
            end

            // any result ends the current sequence
            if (push) begin
                n_pend = '0;
                n_lead = '0;
                n_seen = 1'b0;
                n_acc  = '0;
                if (entry.err != ERR_OK) begin
                    n_discard = !i_string_end;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_lead    <= '0;
            r_seen    <= 1'b0;
            r_acc     <= '0;
            r_discard <= 1'b0;
        end else if (accept) begin
            r_pend    <= n_pend;
            r_lead    <= n_lead;
            r_seen    <= n_seen;
            r_acc     <= n_acc;
            r_discard <= n_discard;
        end
    end

    assign o_entry = entry;
    assign o_push  = accept && push;

endmodule

`default_nettype wire

// ===== src/utd_fifo.sv =====
// Short result queue between the decoder front end and the output stage.
// Register-based circular buffer. Depends on utd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  utd_pkg::t_entry      i_entry,
    input  wire logic            i_pop,
    output utd_pkg::t_entry      o_entry,
    output utd_pkg::t_q_stat     o_stat
);
    import utd_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]     r_count,  n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== src/utd_back.sv =====
// Output stage: pops queue entries and drives the result register.
// A surrogate pair is sent as two results, high surrogate first. Depends on utd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  utd_pkg::t_entry      i_entry,
    input  utd_pkg::t_q_stat     i_stat,
    output logic                 o_pop,
    input  wire logic            i_stall,
    output logic                 o_valid,
    output logic [15:0]          o_code_unit,
    output logic                 o_unit_present,
    output logic [2:0]           o_error_kind,
    output logic                 o_last_of_string
);
    import utd_pkg::*;

    logic        r_valid;
    logic        r_half;        // low surrogate still to send
    logic [15:0] r_lo_unit;
    logic        r_lo_last;
    logic [15:0] r_unit;
    logic        r_present;
    t_err        r_err;
    logic        r_last;
    logic        load;

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && !r_half && !i_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            if (r_half) begin
                r_valid <= 1'b1;
                r_half  <= 1'b0;
            end else if (!i_stat.empty) begin
                r_valid <= 1'b1;
                r_half  <= i_entry.pair;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_half) begin
                r_unit    <= r_lo_unit;
                r_present <= 1'b1;
                r_err     <= ERR_OK;
                r_last    <= r_lo_last;
            end else if (!i_stat.empty) begin
                r_unit    <= i_entry.unit_hi;
                r_present <= i_entry.present;
                r_err     <= i_entry.err;
                r_last    <= i_entry.last && !i_entry.pair;
                r_lo_unit <= i_entry.unit_lo;
                r_lo_last <= i_entry.last;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_code_unit      = r_unit;
    assign o_unit_present   = r_present;
    assign o_error_kind     = r_err;
    assign o_last_of_string = r_last;

endmodule

`default_nettype wire

// ===== src/utf8_to_utf16_decoder_top.sv =====
// UTF-8 to UTF-16 decoder, top level.
// Input channel: one UTF-8 byte per item (i_data_byte, i_string_end), taken
// when i_valid is high and o_stall is low.
// Output channel: one UTF-16 result per item (o_code_unit, o_unit_present,
// o_error_kind, o_last_of_string), taken when o_valid is high and i_stall low.
// Throughput: one byte per cycle while o_stall is low. A four-byte character yields
// a surrogate pair, which is sent on the output as two results.
// A result is written to the queue at the edge that accepts the byte completing
// it, and is loaded from there into the output register when that register is free.
// A 4-entry queue between front end and output stage absorbs surrogate pairs
// and short output stalls; o_stall rises only when that queue is full.
// While i_stall is high the output register holds its result unchanged.
// An error gives one result with last_of_string set and the rest of the
// string is dropped up to the byte marked string_end.
// Synchronous active-low reset empties the queue and clears decoder state;
// no clearing pass is needed, the block accepts bytes right after reset.
// Depends on utd_pkg, utd_front, utd_fifo and utd_back.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_string_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_code_unit,
    output logic             o_unit_present,
    output logic [2:0]       o_error_kind,
    output logic             o_last_of_string
);
    import utd_pkg::*;

    t_entry  push_entry;
    t_entry  head_entry;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    utd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_string_end (i_string_end),
        .i_full       (q_stat.full),
        .o_entry      (push_entry),
        .o_push       (push)
    );

    utd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    utd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (head_entry),
        .i_stat           (q_stat),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_code_unit      (o_code_unit),
        .o_unit_present   (o_unit_present),
        .o_error_kind     (o_error_kind),
        .o_last_of_string (o_last_of_string)
    );

    assign o_stall = q_stat.full;

endmodule

`default_nettype wire

// ===== src/utd_checker.sv =====
// Port-level checker for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on utd_pkg and utf8_to_utf16_decoder_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_to_utf16_decoder_top_assert.svh"

module utd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [15:0] o_code_unit,
    input  wire logic        o_unit_present,
    input  wire logic [2:0]  o_error_kind,
    input  wire logic        o_last_of_string
);
    import utd_pkg::*;

    logic hi_surr;
    assign hi_surr = o_valid && o_unit_present && (o_code_unit[15:10] == HI_SURR);

    // stalled result holds
    `UTD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_code_unit) && $stable(o_last_of_string) && $stable(o_error_kind))

    // an error result carries no unit and closes the string
    `UTD_ASSERT_NOW(a_err_last, i_clk, i_rst_n, o_valid && (o_error_kind != ERR_OK),
        o_last_of_string && !o_unit_present)

    // a high surrogate never ends a string
    `UTD_ASSERT_NOW(a_hi_not_last, i_clk, i_rst_n, hi_surr, !o_last_of_string)

    // the low half follows a taken high surrogate in the very next cycle
    `UTD_ASSERT_NEXT(a_pair_next, i_clk, i_rst_n, hi_surr && !i_stall,
        o_valid && o_unit_present && (o_code_unit[15:10] == LO_SURR))

endmodule

bind utf8_to_utf16_decoder_top utd_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_code_unit      (o_code_unit),
    .o_unit_present   (o_unit_present),
    .o_error_kind     (o_error_kind),
    .o_last_of_string (o_last_of_string)
);

`default_nettype wire

// ===== bench/tb_utf8_to_utf16_decoder_top.sv =====
// Self-checking bench for utf8_to_utf16_decoder_top: directed and random UTF-8 strings
// are fed byte by byte, and an in-bench decoder predicts every UTF-16 result.
// Depends on utd_pkg and the RTL under src only.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder_top;
    import utd_pkg::*;

    typedef struct {
        logic [15:0] unit;
        logic        present;
        t_err        err;
        logic        last;
    } t_utf16_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_string_end = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_code_unit;
    logic        o_unit_present;
    logic [2:0]  o_error_kind;
    logic        o_last_of_string;

    utf8_to_utf16_decoder_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_string_end     (i_string_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_unit      (o_code_unit),
        .o_unit_present   (o_unit_present),
        .o_error_kind     (o_error_kind),
        .o_last_of_string (o_last_of_string)
    );

    // decoder state mirrored by the bench
    logic [1:0]  dec_pending = '0;
    logic [7:0]  dec_lead = '0;
    logic        dec_second = 1'b0;
    logic [20:0] dec_point = '0;
    logic        dec_drop = 1'b0;

    t_utf16_result units_due[$];
    t_utf16_result want;
    logic [7:0]    str_bytes[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int n_fail = 0;
    int n_bytes = 0;
    int n_strings = 0;
    int n_units = 0;
    int n_err_results = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d results still due at %0t", units_due.size(), $time);
        $display("tb_utf8_to_utf16_decoder_top NOT OK");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // ---------------- prediction ----------------
    function automatic void push_unit(logic [15:0] u, logic p, t_err e, logic l);
        t_utf16_result r;
        r.unit = u;
        r.present = p;
        r.err = e;
        r.last = l;
        units_due.push_back(r);
    endfunction

    function automatic void clear_sequence();
        dec_pending = '0;
        dec_lead = '0;
        dec_second = 1'b0;
        dec_point = '0;
    endfunction

    function automatic void decode_error(t_err e, logic end_flag);
        push_unit(16'h0000, 1'b0, e, 1'b1);
        clear_sequence();
        dec_drop = ~end_flag;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic end_flag);
        logic        bad;
        logic [20:0] cp;
        bad = 1'b0;
        if (dec_drop) begin
            if (end_flag) begin
                dec_drop = 1'b0;
                clear_sequence();
            end
            return;
        end
        if (dec_pending == 2'd0) begin
            // zero byte between characters terminates the string early
            if (b == 8'h00) begin
                push_unit(16'h0000, 1'b0, ERR_OK, 1'b1);
                clear_sequence();
                dec_drop = ~end_flag;
                return;
            end
            if (b < 8'h80) begin
                push_unit({8'h00, b}, 1'b1, ERR_OK, end_flag);
                return;
            end
            if (b >= 8'hC2 && b <= 8'hDF) begin
                dec_point = {10'd0, b[4:0], 6'd0};
                dec_pending = 2'd1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                dec_point = {5'd0, b[3:0], 12'd0};
                dec_pending = 2'd2;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                dec_point = {b[2:0], 18'd0};
                dec_pending = 2'd3;
            end else begin
                decode_error(ERR_LEAD, end_flag);
                return;
            end
            dec_lead = b;
            dec_second = 1'b0;
            if (end_flag) decode_error(ERR_TRUNC, end_flag);
            return;
        end
        if (!dec_second) begin
            if (dec_lead == 8'hE0 && (b < 8'hA0 || b > 8'hBF)) bad = 1'b1;
            if (dec_lead == 8'hED && b > 8'h9F) bad = 1'b1;
            if (dec_lead == 8'hF0 && (b < 8'h90 || b > 8'hBF)) bad = 1'b1;
            if (dec_lead == 8'hF4 && b > 8'h8F) bad = 1'b1;
            if (bad) begin
                decode_error(ERR_RANGE, end_flag);
                return;
            end
            dec_second = 1'b1;
        end
        if (b[7:6] != 2'b10) begin
            decode_error(ERR_CONT, end_flag);
            return;
        end
        dec_pending = dec_pending - 2'd1;
        dec_point = dec_point | (21'(b[5:0]) << (6 * dec_pending));
        if (dec_pending != 2'd0) begin
            if (end_flag) decode_error(ERR_TRUNC, end_flag);
            return;
        end
        cp = dec_point;
        clear_sequence();
        if ((cp & 21'h1FF800) == 21'h00D800) begin
            decode_error(ERR_RANGE, end_flag);
            return;
        end
        if (cp >= 21'h010000) begin
            cp = cp - 21'h010000;
            push_unit({6'b110110, cp[19:10]}, 1'b1, ERR_OK, 1'b0);
            push_unit({6'b110111, cp[9:0]}, 1'b1, ERR_OK, end_flag);
        end else begin
            push_unit(cp[15:0], 1'b1, ERR_OK, end_flag);
        end
    endfunction

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (units_due.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected result, exp none, got unit=%h present=%b err=%0d last=%b",
                         $time, o_code_unit, o_unit_present, o_error_kind,
                         o_last_of_string);
            end else begin
                want = units_due.pop_front();
                n_units++;
                if (want.err != ERR_OK) n_err_results++;
                if (o_code_unit !== want.unit || o_unit_present !== want.present ||
                    o_error_kind !== want.err || o_last_of_string !== want.last) begin
                    n_fail++;
                    $display("%0t: mismatch exp unit=%h present=%b err=%0d last=%b, %s",
                             $time, want.unit, want.present, want.err, want.last,
                             $sformatf("got unit=%h present=%b err=%0d last=%b",
                                       o_code_unit, o_unit_present, o_error_kind,
                                       o_last_of_string));
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_byte(input logic [7:0] b, input logic end_flag);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
        @(negedge i_clk);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_string_end <= end_flag;
        do @(posedge i_clk); while (o_stall);
        decode_byte(b, end_flag);
        n_bytes++;
    endtask

    task automatic send_string();
        foreach (str_bytes[k]) send_byte(str_bytes[k], k == str_bytes.size() - 1);
        n_strings++;
        str_bytes.delete();
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (units_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic void encode_point(logic [20:0] cp);
        if (cp < 21'h80) begin
            str_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            str_bytes.push_back({3'b110, cp[10:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            str_bytes.push_back({4'b1110, cp[15:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            str_bytes.push_back({5'b11110, cp[20:18]});
            str_bytes.push_back({2'b10, cp[17:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // multibyte == 1 skips plain ASCII
    function automatic logic [20:0] random_point(logic multibyte);
        logic [20:0] cp;
        case (multibyte ? $urandom_range(1, 3) : $urandom_range(3))
            0: cp = 21'($urandom_range(1, 16'h7F));
            1: cp = 21'($urandom_range(16'h80, 16'h7FF));
            2: begin
                cp = 21'($urandom_range(16'h800, 16'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h8000;
            end
            default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
        return cp;
    endfunction

    // mostly well-formed characters, with noise and broken sequences mixed in
    function automatic void build_string();
        int n_chars;
        int r;
        int start;
        n_chars = $urandom_range(1, 8);
        repeat (n_chars) begin
            r = $urandom_range(99);
            start = str_bytes.size();
            if (r < 75) begin
                encode_point(random_point(1'b0));
            end else if (r < 82) begin
                str_bytes.push_back(8'($urandom_range(255)));
            end else if (r < 88) begin
                encode_point(random_point(1'b1));
                str_bytes[$urandom_range(start + 1, str_bytes.size() - 1)] =
                    8'($urandom_range(255));
            end else if (r < 93) begin
                encode_point(random_point(1'b1));
                repeat ($urandom_range(1, str_bytes.size() - start - 1))
                    void'(str_bytes.pop_back());
            end else if (r < 97) begin
                case ($urandom_range(3))
                    0: str_bytes.push_back(8'hE0);
                    1: str_bytes.push_back(8'hED);
                    2: str_bytes.push_back(8'hF0);
                    default: str_bytes.push_back(8'hF4);
                endcase
                repeat ($urandom_range(1, 3))
                    str_bytes.push_back({2'b10, 6'($urandom_range(63))});
            end else begin
                str_bytes.push_back(8'h00);
            end
        end
    endfunction

    // ---------------- tests ----------------
    task automatic test_valid_forms();
        // a range bound of every length, with the lead bytes that have narrowed second-byte ranges
        str_bytes = '{8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                      8'hED, 8'h9F, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                      8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        drain_results();
    endtask

    task automatic test_error_cases();
        str_bytes = '{8'h00, 8'h41};    // zero byte, then discarded tail
        send_string();
        str_bytes = '{8'hC1, 8'h41};    // bad lead mid-string
        send_string();
        str_bytes = '{8'hF5};           // bad lead on the last byte
        send_string();
        str_bytes = '{8'hE0, 8'h9F};    // second byte below range
        send_string();
        str_bytes = '{8'hF4, 8'h90};    // second byte above range
        send_string();
        str_bytes = '{8'hC2, 8'h00};    // zero as continuation
        send_string();
        str_bytes = '{8'hE1, 8'h80};    // truncated
        send_string();
        str_bytes = '{8'h00};
        send_string();
        drain_results();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int count);
        int first;
        idle_pct = idle;
        stall_pct = stall;
        first = n_bytes;
        while (n_bytes - first < count) begin
            build_string();
            send_string();
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_valid_forms();
        test_error_cases();
        test_random_traffic(0, 0, 125);
        test_random_traffic(76, 0, 125);
        test_random_traffic(0, 76, 125);
        test_random_traffic(14, 14, 125);

        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes in %0d strings; checked %0d results, %0d of them errors.",
                 n_bytes, n_strings, n_units, n_err_results);
        if (n_fail == 0 && units_due.size() == 0) begin
            $display("tb_utf8_to_utf16_decoder_top OK");
        end else begin
            $display("tb_utf8_to_utf16_decoder_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/utd_pkg.sv
src/utd_front.sv
src/utd_fifo.sv
src/utd_back.sv
src/utf8_to_utf16_decoder_top.sv
src/utd_checker.sv
bench/tb_utf8_to_utf16_decoder_top.sv
